/* sv/cic3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic3_pkg
// Shared constants and types of the third-order CIC decimator.
// ----------------------------------------------------------------------------
package cic3_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int ACC_W      = 42;
  localparam int DECIMATION = 32;
  localparam int STAGES     = 3;
  localparam int DIFF_DELAY = 2;
  localparam int CNT_W      = $clog2(DECIMATION);

  localparam int CFG_W      = 8;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_STARTUP_DISCARD = '0;
  localparam logic [CFG_W-1:0]     STARTUP_RESET       = 8'd6;

  typedef logic [ACC_W-1:0] acc_t;

  // One decimated word handed from the integrator section to the comb section.
  typedef struct packed {
    logic valid;
    acc_t value;
  } dec_word_t;

endpackage

/* sv/cic3_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic3_front
// Configuration register, start-up discard counter and input register.
// ----------------------------------------------------------------------------
module cic3_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cic3_pkg::PADDR_W-1:0]      paddr,
  input  logic [cic3_pkg::PDATA_W-1:0]      pwdata,
  output logic [cic3_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [cic3_pkg::SAMPLE_W-1:0] sample_i,
  output logic                              a_valid_o,
  output logic [cic3_pkg::SAMPLE_W-1:0]     a_sample_o,
  input  logic                              integ_ready_i
);
  import cic3_pkg::*;

  logic                  a_vld_q, a_vld_d;
  logic [SAMPLE_W-1:0]   a_sample_q;
  logic [CFG_W-1:0]      startup_q, startup_d;
  logic [CFG_W-1:0]      discard_q, discard_d;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;
  logic                  accept;
  logic                  keep;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_STARTUP_DISCARD);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_STARTUP_DISCARD) ?
                   {{(PDATA_W-CFG_W){1'b0}}, startup_q} : '0;

  assign in_stall_o = a_vld_q && !integ_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  // A sample taken during the discard phase never enters the filter.
  assign keep       = accept && (discard_q == '0);

  always_comb begin
    a_vld_d   = keep || (a_vld_q && !integ_ready_i);
    startup_d = startup_q;
    discard_d = discard_q;
    if (cfg_wr) begin
      startup_d = pwdata[CFG_W-1:0];
      discard_d = pwdata[CFG_W-1:0];
    end else if (accept && (discard_q != '0)) begin
      discard_d = discard_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      startup_q <= STARTUP_RESET;
      discard_q <= STARTUP_RESET;
    end else begin
      a_vld_q   <= a_vld_d;
      startup_q <= startup_d;
      discard_q <= discard_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      a_sample_q <= sample_i;
    end
  end

  assign a_valid_o  = a_vld_q;
  assign a_sample_o = a_sample_q;

endmodule

/* sv/cic3_integ.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic3_integ
// Integrator cascade and decimation counter with its output register.
// ----------------------------------------------------------------------------
module cic3_integ (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          a_valid_i,
  input  logic [cic3_pkg::SAMPLE_W-1:0] a_sample_i,
  output logic                          ready_o,
  output cic3_pkg::dec_word_t           dec_o,
  input  logic                          comb_ready_i
);
  import cic3_pkg::*;

  acc_t              integ_q [STAGES];
  acc_t              integ_d [STAGES];
  acc_t              x;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              b_vld_q, b_vld_d;
  acc_t              b_val_q;
  logic              adv;
  logic              hit;

  assign ready_o = !b_vld_q || comb_ready_i;
  assign adv     = a_valid_i && ready_o;
  assign hit     = (cnt_q == CNT_W'(DECIMATION - 1));

  always_comb begin
    x = {{(ACC_W-SAMPLE_W){a_sample_i[SAMPLE_W-1]}}, a_sample_i};
    for (int s = 0; s < STAGES; s++) begin
      integ_d[s] = integ_q[s] + x;
      x          = integ_d[s];
    end
    cnt_d   = hit ? '0 : cnt_q + 1'b1;
    b_vld_d = (adv && hit) || (b_vld_q && !comb_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES; s++) begin
        integ_q[s] <= '0;
      end
      cnt_q   <= '0;
      b_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        for (int s = 0; s < STAGES; s++) begin
          integ_q[s] <= integ_d[s];
        end
        cnt_q <= cnt_d;
      end
      b_vld_q <= b_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && hit) begin
      b_val_q <= integ_d[STAGES-1];
    end
  end

  assign dec_o.valid = b_vld_q;
  assign dec_o.value = b_val_q;

endmodule

/* sv/cic3_comb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic3_comb
// Comb cascade on the decimated stream and the result register.
// ----------------------------------------------------------------------------
module cic3_comb (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cic3_pkg::dec_word_t              dec_i,
  output logic                             ready_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [cic3_pkg::ACC_W-1:0] filtered_o
);
  import cic3_pkg::*;

  acc_t  dly_q [STAGES][DIFF_DELAY];
  acc_t  stage_in [STAGES];
  acc_t  x;
  acc_t  res_q;
  logic  out_vld_q, out_vld_d;
  logic  take;

  assign ready_o = !out_vld_q || !out_stall_i;
  assign take    = dec_i.valid && ready_o;

  always_comb begin
    x = dec_i.value;
    for (int s = 0; s < STAGES; s++) begin
      stage_in[s] = x;
      x           = x - dly_q[s][DIFF_DELAY-1];
    end
    out_vld_d = take || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES; s++) begin
        for (int d = 0; d < DIFF_DELAY; d++) begin
          dly_q[s][d] <= '0;
        end
      end
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        for (int s = 0; s < STAGES; s++) begin
          for (int d = 1; d < DIFF_DELAY; d++) begin
            dly_q[s][d] <= dly_q[s][d-1];
          end
          dly_q[s][0] <= stage_in[s];
        end
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= x;
    end
  end

  assign out_valid_o = out_vld_q;
  assign filtered_o  = res_q;

endmodule

/* sv/cic3_decimator_r32_n2.sv */
`timescale 1ns / 1ps
// The last sample of a decimation block passes the input register, the integrator
// output register and the result register before the block's result is valid.
// Throughput: one sample per cycle while in_stall_o is low; the three chained 42-bit integrator adds set it.
// One result leaves for every 32 filtered samples.
// Reset clears all integrators, comb delays and the decimation count, and loads
// a start-up discard of six samples.
// ----------------------------------------------------------------------------
// cic3_decimator_r32_n2
// Third-order CIC decimator, rate 32, differential delay 2, gain 2^18.
// ----------------------------------------------------------------------------
module cic3_decimator_r32_n2 (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cic3_pkg::PADDR_W-1:0]         paddr,
  input  logic [cic3_pkg::PDATA_W-1:0]         pwdata,
  output logic [cic3_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [cic3_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [cic3_pkg::ACC_W-1:0]    filtered_o
);
  import cic3_pkg::*;

  logic                a_valid;
  logic [SAMPLE_W-1:0] a_sample;
  logic                integ_ready;
  logic                comb_ready;
  dec_word_t           dec;

  cic3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .a_valid_o     (a_valid),
    .a_sample_o    (a_sample),
    .integ_ready_i (integ_ready)
  );

  cic3_integ u_integ (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .a_valid_i    (a_valid),
    .a_sample_i   (a_sample),
    .ready_o      (integ_ready),
    .dec_o        (dec),
    .comb_ready_i (comb_ready)
  );

  cic3_comb u_comb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_i       (dec),
    .ready_o     (comb_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o)
  );

endmodule

/* sv/cic3_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic3_checker
// Port-level checks of the CIC decimator, bound to the top level.
// ----------------------------------------------------------------------------
module cic3_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic [cic3_pkg::PADDR_W-1:0]         paddr,
  input logic [cic3_pkg::PDATA_W-1:0]         pwdata,
  input logic [cic3_pkg::PDATA_W-1:0]         prdata,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [cic3_pkg::ACC_W-1:0]    filtered_o
);
  import cic3_pkg::*;

  // The input side only backs up when every stage holds a word and the
  // output is stalled.
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output side can move");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result word shown right after reset");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(filtered_o)))
    else $error("stalled result word changed");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_STARTUP_DISCARD)
      |=> (paddr[PADDR_W-1:2] != REG_STARTUP_DISCARD ||
           prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0])))
    else $error("start-up discard register does not read back");

endmodule

bind cic3_decimator_r32_n2 cic3_checker u_cic3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .filtered_o  (filtered_o)
);
